>>> rtl/mlfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer package
// Shared widths, request codes and the divider handshake type.
// ----------------------------------------------------------------------------
package mlfb_pkg;

  localparam int Columns = 128;
  localparam int Pages   = 8;
  localparam int Rows    = 8 * Pages;
  localparam int MemSize = Columns * Pages;
  localparam int ColW    = $clog2(Columns);
  localparam int PageW   = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int RowW    = PageW + 3;
  localparam int AddrW   = $clog2(MemSize);
  // Widest coordinate span plus sign room for the line quotient.
  localparam int SpanW   = (ColW > RowW) ? ColW : RowW;
  localparam int ProdW   = 2 * SpanW + 1;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_PIXEL = 3'd1,
    REQ_PATT  = 3'd2,
    REQ_LINE  = 3'd3,
    REQ_WBYTE = 3'd4,
    REQ_RBYTE = 3'd5,
    REQ_RSVD6 = 3'd6,
    REQ_RSVD7 = 3'd7
  } req_e;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [SpanW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/mlfb_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlfb_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlfb_pkg::div_req_t req_i,
  output mlfb_pkg::div_rsp_t rsp_o
);
  import mlfb_pkg::*;

  localparam int CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] quo_q, quo_d;
  logic [SpanW:0]   rem_q, rem_d;
  logic [SpanW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SpanW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[SpanW-1:0], quo_q[ProdW-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("divider count left over");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
`endif

endmodule

>>> rtl/mono_lcd_frame_buffer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monochrome LCD frame buffer engine
// Page-organized 128x64 one-bit frame buffer with pixel, pattern, line,
// byte and clear commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      req_type_i .. page_index_i
// result    out        done_o strobe, one cycle  read_data_o, is_read_reply_o
//
// Every command ends in exactly one result strobe, and the next command can
// be accepted in the cycle after the strobe. Byte, pixel and read commands
// pass through memory read, registered data, merge write (none for a read)
// and result. A pattern in one page takes the same steps, one that crosses
// into the next page repeats the read, registered data and merge write there,
// and a zero-height pattern or an unused code goes straight to the result. A
// line plots span+1 pixels; each pixel waits on the restoring divider, then
// runs a read-modify-write, and the result follows the last pixel. Clear
// sweeps all 1024 bytes, one per cycle, then strobes.
// After reset a clearing pass over all bytes runs with busy high.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module mono_lcd_frame_buffer_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type_i,
  input  logic [6:0] col_a_i,
  input  logic [5:0] row_a_i,
  input  logic [6:0] col_b_i,
  input  logic [5:0] row_b_i,
  input  logic [3:0] pattern_height_i,
  input  logic [7:0] byte_value_i,
  input  logic [2:0] page_index_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       is_read_reply_o
);
  import mlfb_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;  // sweep memory to zero
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;  // read issued
  localparam logic [3:0] S_WAIT  = 4'd3;  // read data arrives
  localparam logic [3:0] S_WR    = 4'd4;  // merge and write
  localparam logic [3:0] S_DIV   = 4'd5;  // line pixel: wait on divider
  localparam logic [3:0] S_DONE  = 4'd6;  // emit result

  logic [3:0] state_q, state_d;

  // Frame memory, one write and one registered read per cycle.
  logic [7:0]       mem [MemSize];
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Captured command.
  logic [2:0]       req_q;
  logic             point_q;              // line with equal end points
  logic [7:0]       mask_q, mask_d, pat_q, pat_d;
  logic             second_q, second_d;   // pattern needs the next page
  logic [7:0]       mask2_q, mask2_d, pat2_q, pat2_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [7:0]       rd_res_q, rd_res_d;

  // Line walk registers.
  logic             by_rows_q, by_rows_d;
  logic             neg_q, neg_d;
  logic [SpanW-1:0] span_q, span_d, dabs_q, dabs_d, t_q, t_d;
  logic [ColW-1:0]  cs_q, cs_d;
  logic [RowW-1:0]  rs_q, rs_d;
  logic [7:0]       cursor_q, cursor_d;
  logic [AddrW-1:0] clr_q, clr_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mlfb_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Command decode helpers.
  logic [ColW-1:0] ca, cb;
  logic [RowW-1:0] ra, rb, rp;
  logic [PageW-1:0] pg;
  logic [3:0]      h;
  logic [7:0]      hmask, hpat;
  logic [15:0]     wmask, wpat;
  logic [2:0]      st;
  logic            sgn_c, sgn_r;
  logic [SpanW-1:0] adc, adr;
  logic [ProdW-1:0] prod;
  logic [SpanW-1:0] off;

  always_comb begin
    ca = ColW'(col_a_i);
    cb = ColW'(col_b_i);
    ra = RowW'(row_a_i);
    rb = RowW'(row_b_i);
    pg = (page_index_i > 3'(Pages - 1)) ? PageW'(Pages - 1) : PageW'(page_index_i);
    h  = (pattern_height_i > 4'd8) ? 4'd8 : pattern_height_i;
    rp = ((7'(ra) + 7'(h)) >= 7'(Rows)) ? RowW'(7'(Rows) - 7'(h)) : ra;
    hmask = 8'((9'd1 << h) - 9'd1);
    hpat  = byte_value_i & hmask;
    st    = rp[2:0];
    wmask = {8'd0, hmask} << st;
    wpat  = {8'd0, hpat} << st;
    sgn_c = cb < ca;
    sgn_r = rb < ra;
    adc   = sgn_c ? SpanW'(ca - cb) : SpanW'(cb - ca);
    adr   = sgn_r ? SpanW'(ra - rb) : SpanW'(rb - ra);
    prod  = ProdW'(dabs_q) * ProdW'(t_q);
    off   = SpanW'(div_rsp.quotient);
  end

  // Current line pixel coordinates.
  logic [ColW-1:0] lc;
  logic [RowW-1:0] lr;
  always_comb begin
    if (by_rows_q) begin
      lc = neg_q ? ColW'(cs_q - ColW'(off)) : ColW'(cs_q + ColW'(off));
      lr = RowW'(rs_q + RowW'(t_q));
    end else begin
      lc = ColW'(cs_q + ColW'(t_q));
      lr = neg_q ? RowW'(rs_q - RowW'(off)) : RowW'(rs_q + RowW'(off));
    end
  end

  always_comb begin
    state_d = state_q;
    mask_d = mask_q; pat_d = pat_q; mask2_d = mask2_q; pat2_d = pat2_q;
    second_d = second_q; addr_d = addr_q; rd_res_d = rd_res_q;
    by_rows_d = by_rows_q; neg_d = neg_q; span_d = span_q; dabs_d = dabs_q;
    t_d = t_q; cs_d = cs_q; rs_d = rs_q; cursor_d = cursor_q; clr_d = clr_q;
    we = 1'b0; waddr = addr_q; wdata = '0; raddr = addr_q;
    div_req.start = 1'b0;
    div_req.dividend = prod;
    div_req.divisor = span_q;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(MemSize - 1)) begin
          state_d = (req_q == REQ_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        second_d = 1'b0;
        if (start) begin
          unique case (req_type_i)
            REQ_CLEAR: begin
              clr_d = '0;
              state_d = S_CLEAR;
            end
            REQ_PIXEL: begin
              addr_d = AddrW'({ra[RowW-1:3], ca});
              mask_d = 8'd1 << ra[2:0];
              pat_d  = 8'd1 << ra[2:0];
              state_d = S_RD;
            end
            REQ_PATT: begin
              addr_d = AddrW'({rp[RowW-1:3], ca});
              mask_d = wmask[7:0]; pat_d = wpat[7:0];
              mask2_d = wmask[15:8]; pat2_d = wpat[15:8];
              second_d = (h != 4'd0) && (wmask[15:8] != 8'd0);
              state_d = (h == 4'd0) ? S_DONE : S_RD;
            end
            REQ_LINE: begin
              t_d = '0;
              cursor_d = '0;
              if (adr > adc) begin
                by_rows_d = 1'b1;
                span_d = adr;
                dabs_d = adc;
                cs_d = sgn_r ? cb : ca;
                rs_d = sgn_r ? rb : ra;
                neg_d = sgn_r ? (ca < cb) : (cb < ca);
              end else begin
                by_rows_d = 1'b0;
                span_d = (adc == '0) ? SpanW'(1) : adc;
                dabs_d = adr;
                cs_d = sgn_c ? cb : ca;
                rs_d = sgn_c ? rb : ra;
                neg_d = sgn_c ? (ra < rb) : (rb < ra);
              end
              state_d = S_DIV;
            end
            REQ_WBYTE: begin
              addr_d = AddrW'({pg, ca});
              mask_d = 8'hFF; pat_d = byte_value_i;
              state_d = S_RD;
            end
            REQ_RBYTE: begin
              addr_d = AddrW'({pg, ca});
              state_d = S_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          addr_d = AddrW'({lr[RowW-1:3], lc});
          mask_d = 8'd1 << lr[2:0];
          pat_d  = 8'd1 << lr[2:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_WR;
      end
      S_WR: begin
        rd_res_d = rdata_q;
        if (req_q != REQ_RBYTE) begin
          we = 1'b1;
          wdata = (rdata_q & ~mask_q) | pat_q;
        end
        state_d = S_DONE;
        if (second_q) begin
          second_d = 1'b0;
          addr_d = addr_q + AddrW'(Columns);
          mask_d = mask2_q; pat_d = pat2_q;
          state_d = S_RD;
        end else if (req_q == REQ_LINE) begin
          cursor_d = cursor_q + 8'd1;
          if (t_q != span_q && !point_q) begin
            t_d = t_q + 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // Launch the divider on every entry to the wait-for-divider state.
    if (state_d == S_DIV && state_q != S_DIV) begin
      div_req.start = 1'b1;
      div_req.dividend = (state_q == S_IDLE) ? '0 : ProdW'(dabs_q) * ProdW'(t_d);
      div_req.divisor = (state_q == S_IDLE) ? span_d : span_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      req_q    <= REQ_RSVD6;
      second_q <= 1'b0;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      second_q <= second_d;
      cursor_q <= cursor_d;
      if (state_q == S_IDLE && start) begin
        req_q <= req_type_i;
      end
    end
  end

  // Single-pixel line: both end points equal, flagged at acceptance.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      point_q <= (adc == '0) && (adr == '0);
    end
    mask_q <= mask_d; pat_q <= pat_d; mask2_q <= mask2_d; pat2_q <= pat2_d;
    addr_q <= addr_d; rd_res_q <= rd_res_d;
    by_rows_q <= by_rows_d; neg_q <= neg_d; span_q <= span_d;
    dabs_q <= dabs_d; t_q <= t_d; cs_q <= cs_d; rs_q <= rs_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign is_read_reply_o = done_o && (req_q == REQ_RBYTE);
  assign read_data_o     = is_read_reply_o ? rd_res_q : 8'd0;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_reply_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read_reply_o |-> req_q == REQ_RBYTE) else $error("bad reply flag");
  a_write_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == S_WR) |-> req_q != REQ_RBYTE) else $error("read wrote");
  a_div_only_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> req_q == REQ_LINE) else $error("divider misuse");
`endif

endmodule
